// ===== hw/rtl/servo_output_thruster_mixer_assert.svh =====
// Assertion macros shared by the servo output mixer RTL.
`ifndef SERVO_OUTPUT_THRUSTER_MIXER_ASSERT_SVH
`define SERVO_OUTPUT_THRUSTER_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define SOTM_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("sotm assertion failed");
`define SOTM_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("sotm forbidden condition seen");
`else
`define SOTM_ASSERT(lbl, clk_s, rstn_s, prop)
`define SOTM_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

// ===== hw/rtl/sotm_pkg.sv =====
// Shared types, codes and constants of the servo output mixer.
`timescale 1ns / 1ps
package sotm_pkg;

	localparam int W_IN  = 12;
	localparam int W_PWM = 16;

	// Mix mode register codes.
	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_PASS  = 3'd1;
	localparam logic [2:0] MODE_LEFT  = 3'd2;
	localparam logic [2:0] MODE_RIGHT = 3'd3;
	localparam logic [2:0] MODE_TRIM  = 3'd4;
	localparam logic [2:0] MODE_DIFF  = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_MIX_MODE = 2'd0;
	localparam logic [1:0] REG_HOLD     = 2'd1;
	localparam logic [1:0] REG_OUT_EN   = 2'd2;

	localparam logic [15:0] PWM_MID = 16'd1494;
	localparam logic [15:0] PWM_MIN = 16'd1366;
	localparam logic [15:0] PWM_MAX = 16'd1622;

	localparam logic [11:0] SW_PROP = 12'd1800;
	localparam logic [11:0] SW_IND  = 12'd1700;
	localparam logic [11:0] REV_LIM = 12'd1500;
	localparam logic [11:0] CTL_MID = 12'd1494;

	localparam logic signed [13:0] MIX_SUM  = 14'sd4485;
	localparam logic signed [13:0] DIFF_OFS = 14'sd1495;

	localparam logic signed [12:0] CTL_REF   = 13'sd1686;
	localparam logic signed [12:0] THR_REF   = 13'sd1549;
	localparam logic signed [20:0] RATIO_REF = 21'sd1494;
	localparam logic signed [20:0] RATIO_GAIN = 21'sd50;
	localparam logic signed [20:0] IND_GAIN  = 21'sd5;

	// Clamp limits of the thruster numerators (over 1280 and over 128).
	localparam logic signed [26:0] PROP_LO = -27'sd163840;
	localparam logic signed [26:0] PROP_HI = 27'sd163840;
	localparam logic signed [20:0] IND_LO  = 21'sd174848;
	localparam logic signed [20:0] IND_HI  = 21'sd207616;

	// floor(x / 5) for x up to 1280 as (x * 52429) >> 18.
	localparam logic [11:0] PROP_BIAS = 12'd640;
	localparam logic [15:0] DIV5_MUL  = 16'd52429;
	localparam int          DIV5_SH   = 18;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_KEEP,
		OP_LOAD,
		OP_PASS,
		OP_PROP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [15:0]        val;
		logic signed [13:0] radio;
		logic signed [13:0] thresh;
	} qitem_t;

	typedef struct packed {
		logic [2:0] mix_mode;
		logic       output_enabled;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic val;
	} hold_wr_t;

	function automatic logic signed [13:0] ext14(input logic [11:0] v);
		ext14 = $signed({2'b00, v});
	endfunction

	function automatic logic [15:0] sx16(input logic signed [13:0] v);
		sx16 = {{2{v[13]}}, v};
	endfunction

endpackage

// ===== hw/rtl/sotm_if.sv =====
// Valid/ready channel interfaces for input ticks and servo results.
`timescale 1ns / 1ps
interface sotm_in_if import sotm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            bypass_off;
	logic [W_IN-1:0] a_pulse;
	logic [W_IN-1:0] a_trim;
	logic [W_IN-1:0] a_dead;
	logic [W_IN-1:0] b_pulse;
	logic [W_IN-1:0] b_trim;
	logic [W_IN-1:0] b_dead;
	logic [W_IN-1:0] mode_switch;
	logic [W_IN-1:0] steer_ctl;
	logic [W_IN-1:0] diff_ratio;
	logic [W_IN-1:0] throttle;
	logic [W_IN-1:0] reverse_sel;

	modport source(output valid, bypass_off, a_pulse, a_trim, a_dead, b_pulse, b_trim,
		b_dead, mode_switch, steer_ctl, diff_ratio, throttle, reverse_sel, input ready);
	modport sink(input valid, bypass_off, a_pulse, a_trim, a_dead, b_pulse, b_trim,
		b_dead, mode_switch, steer_ctl, diff_ratio, throttle, reverse_sel, output ready);
endinterface

interface sotm_out_if import sotm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [W_PWM-1:0] pwm;
	logic             write_strobe;

	modport source(output valid, pwm, write_strobe, input ready);
	modport sink(input valid, pwm, write_strobe, output ready);
endinterface

// ===== hw/rtl/sotm_front.sv =====
// Front end: classifies each tick and precomputes mix values and thruster terms.
`timescale 1ns / 1ps
module sotm_front import sotm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	sotm_in_if.sink in_ch,
	output qitem_t item,
	output logic   item_valid,
	input  logic   item_ready
);

	typedef enum logic [2:0] {
		CLS_KEEP,
		CLS_LOAD,
		CLS_PASS,
		CLS_PROP,
		CLS_IND
	} cls_t;

	logic adv1, adv2;

	// Stage 1 decode and arithmetic.
	cls_t               cls;
	logic [15:0]        val;
	logic signed [13:0] radio, thresh;
	logic signed [13:0] trim_r, trim_t, diff_r, diff_t, diff_dis;
	logic               right;
	logic signed [12:0] dctl, dthr;
	logic signed [25:0] prod;
	logic signed [20:0] rdiff, rt_full, rt_dir, ind5, ind_n;
	logic               upos;

	assign trim_r   = MIX_SUM - ext14(in_ch.a_trim) - ext14(in_ch.b_trim);
	assign trim_t   = MIX_SUM - ext14(in_ch.a_dead) - ext14(in_ch.b_dead);
	assign diff_r   = ext14(in_ch.a_pulse) - ext14(in_ch.b_pulse) + DIFF_OFS;
	assign diff_t   = ext14(in_ch.a_dead) - ext14(in_ch.b_dead) + DIFF_OFS;
	assign diff_dis = ext14(in_ch.a_trim) - ext14(in_ch.b_trim) + DIFF_OFS;

	assign right   = (cfg.mix_mode == MODE_RIGHT);
	assign dctl    = CTL_REF - $signed({1'b0, in_ch.steer_ctl});
	assign dthr    = $signed({1'b0, in_ch.throttle}) - THR_REF;
	assign prod    = dctl * dthr;
	assign rdiff   = RATIO_REF - $signed({9'b0, in_ch.diff_ratio});
	assign rt_full = rdiff * RATIO_GAIN;
	assign rt_dir  = right ? rt_full : -rt_full;
	assign ind5    = rdiff * IND_GAIN;
	assign upos    = (in_ch.steer_ctl < CTL_MID) ^ right;
	assign ind_n   = $signed({2'b00, in_ch.steer_ctl, 7'b0}) + (upos ? ind5 : -ind5);

	always_comb begin
		cls    = CLS_KEEP;
		val    = '0;
		radio  = '0;
		thresh = '0;
		unique case (cfg.mix_mode)
			MODE_PASS: begin
				radio  = ext14(in_ch.a_pulse);
				thresh = ext14(in_ch.a_dead);
				val    = {4'b0, in_ch.a_trim};
				cls    = in_ch.bypass_off ? CLS_LOAD : CLS_PASS;
			end
			MODE_LEFT, MODE_RIGHT: begin
				val = PWM_MID;
				priority if (in_ch.bypass_off) begin
					cls = CLS_LOAD;
				end else if (in_ch.mode_switch > SW_PROP) begin
					cls = CLS_PROP;
				end else if (in_ch.mode_switch < SW_IND) begin
					cls = CLS_IND;
				end else begin
					cls = CLS_LOAD;
				end
			end
			MODE_TRIM: begin
				radio  = trim_r;
				thresh = trim_t;
				val    = sx16(trim_r);
				cls    = in_ch.bypass_off ? CLS_LOAD : CLS_PASS;
			end
			MODE_DIFF: begin
				radio  = diff_r;
				thresh = diff_t;
				val    = sx16(diff_dis);
				cls    = in_ch.bypass_off ? CLS_LOAD : CLS_PASS;
			end
			default: begin
				cls = CLS_KEEP;
			end
		endcase
	end

	logic               v_s1;
	cls_t               cls_s1;
	logic [15:0]        val_s1;
	logic signed [13:0] radio_s1, thresh_s1;
	logic signed [25:0] prod_s1;
	logic signed [18:0] rt_s1;
	logic               spos_s1;
	logic signed [20:0] ind_s1;

	assign adv2        = !item_valid || item_ready;
	assign adv1        = !v_s1 || adv2;
	assign in_ch.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_ch.valid) begin
			cls_s1    <= cls;
			val_s1    <= val;
			radio_s1  <= radio;
			thresh_s1 <= thresh;
			prod_s1   <= prod;
			rt_s1     <= rt_dir[18:0];
			spos_s1   <= (in_ch.reverse_sel > REV_LIM);
			ind_s1    <= ind_n;
		end
	end

	// Stage 2: finish the thruster numerators and apply the clamp.
	logic signed [26:0] pm, pn, psh;
	logic [11:0]        px;
	logic signed [20:0] ish;
	qitem_t             nxt;

	assign pm  = 27'(prod_s1) + 27'(rt_s1);
	assign pn  = spos_s1 ? pm : -pm;
	assign psh = pn >>> 8;
	assign px  = psh[11:0] + PROP_BIAS;
	assign ish = ind_s1 >>> 7;

	always_comb begin
		nxt.op     = OP_KEEP;
		nxt.val    = val_s1;
		nxt.radio  = radio_s1;
		nxt.thresh = thresh_s1;
		unique case (cls_s1)
			CLS_KEEP: nxt.op = OP_KEEP;
			CLS_LOAD: nxt.op = OP_LOAD;
			CLS_PASS: nxt.op = OP_PASS;
			CLS_PROP: begin
				priority if (pn < PROP_LO) begin
					nxt.op  = OP_LOAD;
					nxt.val = PWM_MIN;
				end else if (pn > PROP_HI) begin
					nxt.op  = OP_LOAD;
					nxt.val = PWM_MAX;
				end else begin
					// The back end divides the biased quotient by five.
					nxt.op  = OP_PROP;
					nxt.val = {5'b0, px[10:0]};
				end
			end
			CLS_IND: begin
				nxt.op = OP_LOAD;
				priority if (ind_s1 < IND_LO) begin
					nxt.val = PWM_MIN;
				end else if (ind_s1 > IND_HI) begin
					nxt.val = PWM_MAX;
				end else begin
					nxt.val = ish[15:0];
				end
			end
			default: nxt.op = OP_KEEP;
		endcase
	end

	qitem_t item_s2;
	logic   v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			item_s2 <= nxt;
		end
	end

	assign item       = item_s2;
	assign item_valid = v_s2;

endmodule

// ===== hw/rtl/sotm_queue.sv =====
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`include "servo_output_thruster_mixer_assert.svh"
module sotm_queue import sotm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  qitem_t push_item,
	output logic   pop_valid,
	input  logic   pop_ready,
	output qitem_t pop_item
);

	qitem_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push_fire, pop_fire;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = slot_q[rd_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
		wrap_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_fire) begin
				wr_q <= wrap_inc(wr_q);
			end
			if (pop_fire) begin
				rd_q <= wrap_inc(rd_q);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_q] <= push_item;
		end
	end

	`SOTM_ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > QCNT_W'(QDEPTH))
	`SOTM_ASSERT(a_cnt_up, clk, arst_n, push_fire && !pop_fire |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
	`SOTM_ASSERT(a_cnt_down, clk, arst_n, pop_fire && !push_fire |=> cnt_q == $past(cnt_q) - QCNT_W'(1))

endmodule

// ===== hw/rtl/sotm_back.sv =====
// Back end: applies each item to the servo state and holds the result item.
`timescale 1ns / 1ps
`include "servo_output_thruster_mixer_assert.svh"
module sotm_back import sotm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  hold_wr_t hold_wr,
	input  logic     item_valid,
	output logic     item_ready,
	input  qitem_t   item,
	sotm_out_if.source out_ch
);

	logic [15:0]        last_q;
	logic signed [13:0] prior_q;
	logic               holding_q;
	logic               strobe_q;
	logic               out_valid_q;
	logic               take;

	logic signed [14:0] diff, adiff;
	logic               moved;
	logic [15:0]        radio16;
	logic [26:0]        div_p;
	logic [15:0]        prop_pwm;

	assign item_ready = !out_valid_q || out_ch.ready;
	assign take       = item_valid && item_ready;

	// Hold logic: compare against the last pass input that was taken while the hold was off.
	assign diff    = 15'(item.radio) - 15'(prior_q);
	assign adiff   = (diff < 0) ? -diff : diff;
	assign moved   = adiff > 15'(item.thresh);
	assign radio16 = sx16(item.radio);

	assign div_p    = {16'b0, item.val[10:0]} * {11'b0, DIV5_MUL};
	assign prop_pwm = PWM_MIN + {7'b0, div_p[DIV5_SH +: 9]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			prior_q     <= '0;
			holding_q   <= 1'b0;
			strobe_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				strobe_q    <= cfg.output_enabled;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (hold_wr.en) begin
				holding_q <= hold_wr.val;
			end else if (take && item.op == OP_PASS && holding_q && moved) begin
				holding_q <= 1'b0;
			end
			if (take) begin
				unique case (item.op)
					OP_KEEP: last_q <= last_q;
					OP_LOAD: last_q <= item.val;
					OP_PASS: begin
						if (!holding_q) begin
							last_q  <= radio16;
							prior_q <= item.radio;
						end else if (moved) begin
							last_q <= radio16;
						end
					end
					OP_PROP: last_q <= prop_pwm;
				endcase
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.pwm          = last_q;
	assign out_ch.write_strobe = strobe_q;

	`SOTM_ASSERT(a_hold_clear, clk, arst_n, $fell(holding_q) |-> $past(hold_wr.en) || ($past(take) && $past(item.op) == OP_PASS))
	`SOTM_ASSERT(a_prop_range, clk, arst_n, $past(take) && $past(item.op) == OP_PROP |-> last_q >= PWM_MIN && last_q <= PWM_MAX)
	`SOTM_ASSERT_NEVER(a_stall_take, clk, arst_n, take && out_valid_q && !out_ch.ready)

endmodule

// ===== hw/rtl/servo_output_thruster_mixer.sv =====
// A result item passes two front stages and a queue slot ahead of the back end's update.
// Throughput: one tick per cycle while the result channel is not stalled; the front, queue
// and back end each move one item a cycle.
// Reset: asynchronous and active low; clears the pipeline, the queue, the servo state and
// the registers (mix mode none, hold off, output enabled).
`timescale 1ns / 1ps
module servo_output_thruster_mixer import sotm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data,
	sotm_in_if.sink    in_ch,
	sotm_out_if.source out_ch
);

	cfg_t     cfg_q;
	hold_wr_t hold_wr;
	qitem_t   f_item, b_item;
	logic     f_valid, f_ready, b_valid, b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mix_mode       <= MODE_NONE;
			cfg_q.output_enabled <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_MIX_MODE) begin
				cfg_q.mix_mode <= cfg_data;
			end
			if (cfg_index == REG_OUT_EN) begin
				cfg_q.output_enabled <= cfg_data[0];
			end
		end
	end

	// Writing the hold register also arms or disarms the hold in the back end.
	assign hold_wr.en  = cfg_we && (cfg_index == REG_HOLD);
	assign hold_wr.val = cfg_data[0];

	sotm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_ch      (in_ch),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	sotm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	sotm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.hold_wr    (hold_wr),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.out_ch     (out_ch)
	);

endmodule

// ===== verif/tb_servo_output_thruster_mixer.sv =====
`timescale 1ns / 1ps
// Testbench of the servo output mixer: a directed table, then random ticks per mix mode.
module tb_servo_output_thruster_mixer;
	import sotm_pkg::*;

	localparam logic [2:0] MODE_SPARE = 3'd6;
	localparam int NUM_PHASES = 26;
	localparam int TICKS_PER_PHASE = 75;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		logic        bypass_off;
		logic [11:0] a_pulse;
		logic [11:0] a_trim;
		logic [11:0] a_dead;
		logic [11:0] b_pulse;
		logic [11:0] b_trim;
		logic [11:0] b_dead;
		logic [11:0] mode_switch;
		logic [11:0] steer_ctl;
		logic [11:0] diff_ratio;
		logic [11:0] throttle;
		logic [11:0] reverse_sel;
	} tick_t;

	typedef struct {
		logic [15:0] pwm;
		logic        strobe;
	} servo_out_t;

	typedef struct {
		logic [2:0]  mode;
		bit          arm;
		bit          hold_val;
		bit          en;
		tick_t       t;
		bit          typed;
		logic [15:0] want;
	} table_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [2:0] cfg_data;

	sotm_in_if  in_ch();
	sotm_out_if out_ch();

	servo_output_thruster_mixer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Mirror of the registers and of the servo state.
	logic [2:0]  cfg_mode = MODE_NONE;
	bit          cfg_en = 1'b1;
	logic [15:0] srv_last = '0;
	logic [15:0] srv_prior = '0;
	bit          srv_holding = 1'b0;

	servo_out_t  pending_pwm[$];
	table_row_t  dir_table[$];

	int gap_pct;
	int stall_pct;
	int fail_count = 0;
	int cycles = 0;
	int ticks_sent = 0;
	int results_seen = 0;
	int rearm_count = 0;
	int thrust_ticks = 0;
	int bypass_ticks = 0;
	int mode_ticks[8];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic tick_t mk_tick(input bit off, input int ap, at, ad, bp, bt, bd,
		sw, ctl, ratio, thr, rev);
		tick_t t;
		t.bypass_off  = off;
		t.a_pulse     = 12'(ap);
		t.a_trim      = 12'(at);
		t.a_dead      = 12'(ad);
		t.b_pulse     = 12'(bp);
		t.b_trim      = 12'(bt);
		t.b_dead      = 12'(bd);
		t.mode_switch = 12'(sw);
		t.steer_ctl   = 12'(ctl);
		t.diff_ratio  = 12'(ratio);
		t.throttle    = 12'(thr);
		t.reverse_sel = 12'(rev);
		return t;
	endfunction

	function automatic void add_row(input logic [2:0] mode, input bit arm, input bit hv,
		input bit en, input tick_t t, input bit typed, input logic [15:0] want);
		table_row_t row;
		row.mode     = mode;
		row.arm      = arm;
		row.hold_val = hv;
		row.en       = en;
		row.t        = t;
		row.typed    = typed;
		row.want     = want;
		dir_table.push_back(row);
	endfunction

	function automatic logic [11:0] near_val(input int c, input int span);
		int v;
		v = c - span + int'($urandom_range(0, 2 * span));
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	// Dead-zone hold: once armed, the output only follows a move wider than the threshold.
	function automatic void follow_input(input int radio, input int thresh);
		int d;
		if (!srv_holding) begin
			srv_last  = 16'(radio);
			srv_prior = srv_last;
		end else begin
			d = radio - int'($signed(srv_prior));
			if (d < 0)
				d = -d;
			if (d > thresh) begin
				srv_last    = 16'(radio);
				srv_holding = 1'b0;
			end
		end
	endfunction

	// Value base + n/d, clamped to the servo range before the floor is taken.
	function automatic logic [15:0] floor_pwm(input longint base, input longint n,
		input longint d);
		longint q;
		if (n < (1366 - base) * d)
			return PWM_MIN;
		if (n > (1622 - base) * d)
			return PWM_MAX;
		q = n / d;
		if (n % d != 0 && n < 0)
			q = q - 1;
		return 16'(base + q);
	endfunction

	function automatic logic [15:0] thrust_pwm(input bit right, input tick_t t);
		longint ctl;
		longint ratio;
		longint thr;
		longint s;
		longint u;
		longint n;
		ctl   = t.steer_ctl;
		ratio = t.diff_ratio;
		thr   = t.throttle;
		if (t.mode_switch > SW_PROP) begin
			s = (t.reverse_sel > REV_LIM) ? 1 : -1;
			n = s * (1686 - ctl) * (thr - 1549) + (right ? s : -s) * 50 * (1494 - ratio);
			return floor_pwm(1494, n, 1280);
		end
		if (t.mode_switch < SW_IND) begin
			u = (ctl < 1494) ? 1 : -1;
			if (right)
				u = -u;
			n = 128 * ctl + u * 5 * (1494 - ratio);
			return floor_pwm(0, n, 128);
		end
		return PWM_MID;
	endfunction

	function automatic servo_out_t step_servo(input tick_t t);
		servo_out_t r;
		int ap;
		int at;
		int ad;
		int bp;
		int bt;
		int bd;
		ap = t.a_pulse;
		at = t.a_trim;
		ad = t.a_dead;
		bp = t.b_pulse;
		bt = t.b_trim;
		bd = t.b_dead;
		case (cfg_mode)
		MODE_PASS: begin
			if (t.bypass_off)
				srv_last = 16'(at);
			else
				follow_input(ap, ad);
		end
		MODE_LEFT, MODE_RIGHT: begin
			srv_last = t.bypass_off ? PWM_MID : thrust_pwm(cfg_mode == MODE_RIGHT, t);
		end
		MODE_TRIM: begin
			if (t.bypass_off)
				srv_last = 16'(4485 - at - bt);
			else
				follow_input(4485 - at - bt, 4485 - ad - bd);
		end
		MODE_DIFF: begin
			if (t.bypass_off)
				srv_last = 16'(at - bt + 1495);
			else
				follow_input(ap - bp + 1495, ad - bd + 1495);
		end
		default: ;
		endcase
		r.pwm    = srv_last;
		r.strobe = cfg_en;
		return r;
	endfunction

	// Full-range fields, mostly reshaped so that holds, dead zones and thruster bands are hit.
	function automatic tick_t rand_tick(input logic [2:0] mode);
		tick_t t;
		int d;
		t.bypass_off  = ($urandom_range(0, 7) == 0);
		t.a_pulse     = 12'($urandom_range(0, 4095));
		t.a_trim      = 12'($urandom_range(0, 4095));
		t.a_dead      = 12'($urandom_range(0, 4095));
		t.b_pulse     = 12'($urandom_range(0, 4095));
		t.b_trim      = 12'($urandom_range(0, 4095));
		t.b_dead      = 12'($urandom_range(0, 4095));
		t.mode_switch = 12'($urandom_range(0, 4095));
		t.steer_ctl   = 12'($urandom_range(0, 4095));
		t.diff_ratio  = 12'($urandom_range(0, 4095));
		t.throttle    = 12'($urandom_range(0, 4095));
		t.reverse_sel = 12'($urandom_range(0, 4095));
		if ($urandom_range(0, 3) != 0) begin
			case (mode)
			MODE_PASS: begin
				t.a_pulse = near_val(1500, 100);
				t.a_trim  = near_val(1500, 100);
				t.a_dead  = 12'($urandom_range(0, 80));
			end
			MODE_TRIM: begin
				t.a_trim  = near_val(1500, 60);
				t.b_trim  = near_val(1500, 60);
				d = $urandom_range(2000, 2400);
				t.a_dead  = 12'(d);
				t.b_dead  = 12'(4485 - d - int'($urandom_range(0, 80)));
			end
			MODE_DIFF: begin
				t.a_pulse = near_val(1500, 60);
				t.b_pulse = near_val(1500, 60);
				d = $urandom_range(0, 2000);
				t.a_dead  = 12'(d);
				t.b_dead  = 12'(d + 1495 - int'($urandom_range(0, 80)));
			end
			MODE_LEFT, MODE_RIGHT: begin
				case ($urandom_range(0, 7))
				0, 1: t.mode_switch = 12'($urandom_range(0, 1699));
				2, 3: t.mode_switch = 12'($urandom_range(1801, 4095));
				4: t.mode_switch = 12'($urandom_range(1700, 1800));
				5: t.mode_switch = 12'($urandom_range(1699, 1700));
				6: t.mode_switch = 12'($urandom_range(1800, 1801));
				default: ;
				endcase
				if ($urandom_range(0, 7) == 0)
					t.steer_ctl = 12'($urandom_range(1493, 1494));
				else
					t.steer_ctl = near_val(1494, 200);
				t.diff_ratio  = near_val(1494, 600);
				t.throttle    = near_val(1549, 200);
				t.reverse_sel = near_val(1500, 3);
			end
			default: ;
			endcase
		end
		return t;
	endfunction

	task automatic program_reg(input logic [1:0] idx, input logic [2:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
		REG_MIX_MODE: cfg_mode = data;
		REG_HOLD: srv_holding = data[0];
		REG_OUT_EN: cfg_en = data[0];
		default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_pwm.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_tick(input tick_t t, input bit typed, input logic [15:0] want);
		servo_out_t r;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.bypass_off  <= t.bypass_off;
		in_ch.a_pulse     <= t.a_pulse;
		in_ch.a_trim      <= t.a_trim;
		in_ch.a_dead      <= t.a_dead;
		in_ch.b_pulse     <= t.b_pulse;
		in_ch.b_trim      <= t.b_trim;
		in_ch.b_dead      <= t.b_dead;
		in_ch.mode_switch <= t.mode_switch;
		in_ch.steer_ctl   <= t.steer_ctl;
		in_ch.diff_ratio  <= t.diff_ratio;
		in_ch.throttle    <= t.throttle;
		in_ch.reverse_sel <= t.reverse_sel;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		r = step_servo(t);
		if (typed)
			r.pwm = want;
		pending_pwm.push_back(r);
		ticks_sent++;
		mode_ticks[cfg_mode]++;
		if (cfg_mode == MODE_LEFT || cfg_mode == MODE_RIGHT)
			thrust_ticks++;
		if (t.bypass_off)
			bypass_ticks++;
	endtask

	// Result side backpressure.
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : watch_results
		servo_out_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			results_seen++;
			if (pending_pwm.size() == 0) begin
				if (fail_count < 10)
					$display("result %0d arrived with no tick outstanding: pwm %0d",
						results_seen, out_ch.pwm);
				fail_count++;
			end else begin
				want = pending_pwm.pop_front();
				if (out_ch.pwm !== want.pwm || out_ch.write_strobe !== want.strobe) begin
					if (fail_count < 10)
						$display("result %0d: pwm %0d expected %0d, strobe %b expected %b",
							results_seen, out_ch.pwm, want.pwm, out_ch.write_strobe,
							want.strobe);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_pwm.size());
			$display("servo_output_thruster_mixer test failed");
			$finish;
		end
	end

	initial begin : stimulus
		table_row_t row;
		logic [2:0] mode;
		bit hold_on;
		bit en_on;
		int p;
		int i;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_MIX_MODE;
		cfg_data          <= '0;
		in_ch.valid       <= 1'b0;
		in_ch.bypass_off  <= 1'b0;
		in_ch.a_pulse     <= '0;
		in_ch.a_trim      <= '0;
		in_ch.a_dead      <= '0;
		in_ch.b_pulse     <= '0;
		in_ch.b_trim      <= '0;
		in_ch.b_dead      <= '0;
		in_ch.mode_switch <= '0;
		in_ch.steer_ctl   <= '0;
		in_ch.diff_ratio  <= '0;
		in_ch.throttle    <= '0;
		in_ch.reverse_sel <= '0;
		gap_pct   = 20;
		stall_pct = 20;
		foreach (mode_ticks[k])
			mode_ticks[k] = 0;

		// Columns: mode, arm hold, hold value, output enable, tick, typed, expected pwm.
		// Tick: off, a pulse/trim/dead, b pulse/trim/dead, switch, ctl, ratio, throttle, rev.
		add_row(MODE_NONE, 0, 0, 1, mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0);
		add_row(MODE_PASS, 0, 0, 1, mk_tick(0, 4095, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 4095);
		add_row(MODE_PASS, 0, 0, 1, mk_tick(1, 4095, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0);
		add_row(MODE_PASS, 0, 0, 1, mk_tick(0, 0, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0);
		add_row(MODE_PASS, 1, 1, 1, mk_tick(0, 1500, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
		add_row(MODE_PASS, 1, 1, 1, mk_tick(0, 1550, 0, 4095, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
		add_row(MODE_PASS, 0, 0, 1, mk_tick(0, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
		add_row(MODE_LEFT, 0, 0, 1,
			mk_tick(0, 0, 0, 0, 0, 0, 0, 4095, 0, 1494, 4095, 4095), 1, 1622);
		add_row(MODE_LEFT, 0, 0, 1,
			mk_tick(0, 0, 0, 0, 0, 0, 0, 4095, 0, 1494, 4095, 0), 1, 1366);
		add_row(MODE_LEFT, 0, 0, 1, mk_tick(0, 0, 0, 0, 0, 0, 0, 1750, 0, 0, 0, 0), 1, 1494);
		add_row(MODE_LEFT, 0, 0, 1, mk_tick(0, 0, 0, 0, 0, 0, 0, 1800, 0, 0, 0, 0), 1, 1494);
		add_row(MODE_LEFT, 0, 0, 1,
			mk_tick(0, 0, 0, 0, 0, 0, 0, 1700, 4095, 4095, 4095, 4095), 1, 1494);
		add_row(MODE_LEFT, 0, 0, 1,
			mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 1494, 1494, 0, 0), 1, 1494);
		add_row(MODE_LEFT, 0, 0, 1,
			mk_tick(0, 0, 0, 0, 0, 0, 0, 1699, 1400, 0, 0, 0), 0, 0);
		add_row(MODE_RIGHT, 0, 0, 1,
			mk_tick(0, 0, 0, 0, 0, 0, 0, 1801, 1600, 100, 1700, 1501), 0, 0);
		add_row(MODE_RIGHT, 0, 0, 1,
			mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 1500, 4095, 0, 0), 0, 0);
		add_row(MODE_RIGHT, 0, 0, 1,
			mk_tick(0, 0, 0, 0, 0, 0, 0, 1801, 4095, 4095, 0, 1500), 0, 0);
		add_row(MODE_RIGHT, 0, 0, 1,
			mk_tick(1, 0, 0, 0, 0, 0, 0, 4095, 0, 0, 4095, 4095), 1, 1494);
		add_row(MODE_TRIM, 0, 0, 1,
			mk_tick(0, 0, 4095, 4095, 0, 4095, 4095, 0, 0, 0, 0, 0), 0, 0);
		add_row(MODE_TRIM, 0, 0, 1, mk_tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 4485);
		add_row(MODE_DIFF, 0, 0, 1, mk_tick(0, 4095, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
		add_row(MODE_DIFF, 0, 0, 1, mk_tick(1, 0, 0, 0, 0, 4095, 0, 0, 0, 0, 0, 0), 0, 0);
		add_row(MODE_DIFF, 1, 1, 1,
			mk_tick(0, 1500, 0, 4095, 1500, 0, 0, 0, 0, 0, 0, 0), 0, 0);
		add_row(MODE_SPARE, 0, 0, 1,
			mk_tick(0, 4095, 4095, 4095, 4095, 4095, 4095, 0, 0, 0, 0, 0), 0, 0);
		add_row(MODE_PASS, 0, 0, 0, mk_tick(0, 2000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[k]) begin
			row = dir_table[k];
			if (row.mode != cfg_mode || row.en != cfg_en || row.arm) begin
				drain();
				if (row.mode != cfg_mode)
					program_reg(REG_MIX_MODE, row.mode);
				if (row.en != cfg_en)
					program_reg(REG_OUT_EN, {2'b00, row.en});
				if (row.arm)
					program_reg(REG_HOLD, {2'b00, row.hold_val});
			end
			put_tick(row.t, row.typed, row.want);
		end

		for (p = 0; p < NUM_PHASES; p++) begin
			mode    = 3'(p % 7);
			hold_on = (p % 3 != 0);
			en_on   = (p % 5 != 4);
			gap_pct   = (p % 6 == 3 || p >= NUM_PHASES - 2) ? 0 : 12;
			stall_pct = (p % 6 == 5 || p >= NUM_PHASES - 2) ? 0 : 12;
			drain();
			program_reg(REG_MIX_MODE, mode);
			program_reg(REG_HOLD, {2'b00, hold_on});
			program_reg(REG_OUT_EN, {2'b00, en_on});
			for (i = 0; i < TICKS_PER_PHASE; i++) begin
				// A hold releases for good once moved, so it is armed again now and then.
				if (hold_on && i % 16 == 15 &&
					(mode == MODE_PASS || mode == MODE_TRIM || mode == MODE_DIFF)) begin
					drain();
					program_reg(REG_HOLD, 3'd1);
					rearm_count++;
				end
				put_tick(rand_tick(mode), 1'b0, '0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d ticks, checked %0d results; per mix mode 0..6: %0d %0d %0d %0d %0d %0d %0d.",
			ticks_sent, results_seen, mode_ticks[0], mode_ticks[1], mode_ticks[2],
			mode_ticks[3], mode_ticks[4], mode_ticks[5], mode_ticks[6]);
		$display("%0d thruster ticks, %0d with bypass off, %0d hold re-arms, %0d mismatches.",
			thrust_ticks, bypass_ticks, rearm_count, fail_count);
		if (fail_count == 0)
			$display("servo_output_thruster_mixer test passed");
		else
			$display("servo_output_thruster_mixer test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sotm_pkg.sv
hw/rtl/sotm_if.sv
hw/rtl/sotm_front.sv
hw/rtl/sotm_queue.sv
hw/rtl/sotm_back.sv
hw/rtl/servo_output_thruster_mixer.sv
verif/tb_servo_output_thruster_mixer.sv
